// ===== design/fdi_pkg.sv =====
// Shared widths, mode codes and control types for the FIR resampler.
package fdi_pkg;

    // Q1.15 sample width
    localparam int SAMPLE_W = 16;
    // Coefficient width: Q1.17 taps, with headroom for the interpolation gain
    localparam int COEF_W = 25;
    // Fraction bits of the coefficients, dropped when rounding to Q1.15
    localparam int FRAC_SHIFT = 17;
    localparam int RND_HALF = 1 << (FRAC_SHIFT - 1);
    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    // Mode register codes
    localparam logic MODE_DECIMATE = 1'b0;
    localparam logic MODE_INTERP = 1'b1;

    // Per-cycle control travelling with each tap into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

// ===== design/fdi_cell.sv =====
// One delay-line cell: a sample register loaded from its neighbour on each shift.
module fdi_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [fdi_pkg::SAMPLE_W-1:0]  i_d,
    output logic [fdi_pkg::SAMPLE_W-1:0]  o_q
);

    logic [fdi_pkg::SAMPLE_W-1:0] r_q;
    logic [fdi_pkg::SAMPLE_W-1:0] n_q;

    // Take the neighbour's sample on a shift, else hold
    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    // Clear to silence at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/fdi_mac.sv =====
// Coefficient ROM, serial multiply-accumulate and Q1.15 round/saturate stage.
module fdi_mac #(
    parameter int RATIO      = 6,
    parameter int PHASE_TAPS = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  fdi_pkg::t_mac_ctrl                          i_ctrl,
    input  logic [$clog2(RATIO*PHASE_TAPS)-1:0]         i_tap_idx,
    input  logic signed [fdi_pkg::SAMPLE_W-1:0]         i_tap,
    input  logic                                        i_mode,
    output logic                                        o_done,
    output logic signed [fdi_pkg::SAMPLE_W-1:0]         o_result
);

    localparam int NTAPS = RATIO * PHASE_TAPS;
    localparam int TW    = $clog2(NTAPS);
    localparam int SW    = fdi_pkg::SAMPLE_W;
    localparam int KW    = fdi_pkg::COEF_W;
    localparam int PW    = SW + KW;
    localparam int ACC_W = PW + TW;

    localparam longint TAP_M = longint'(NTAPS - 1);
    localparam longint Q30 = 64'sd1073741824;
    localparam longint unsigned Q30U = 64'd1073741824;
    localparam longint unsigned SINC_DEN = 64'(40 * RATIO);
    localparam longint unsigned WIN_DEN = 64'(4 * (NTAPS - 1));
    // Centre tap of the sinc: 0.45*pi in Q30 over the ratio
    localparam longint SINC_CENTRE = 64'sd1517966742 / RATIO;

    // Unsigned quotient by shift and subtract
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine of a phase given in Q32 turns, Q30 result, quarter-wave Taylor series
    function automatic longint f_sin_q30(input longint unsigned u);
        longint unsigned q;
        longint unsigned f;
        longint unsigned a;
        longint unsigned t2;
        longint unsigned r;
        q = (u >> 30) & 64'd3;
        f = u & 64'h3FFF_FFFF;
        if ((q & 64'd1) != 64'd0) begin
            f = Q30U - f;
        end
        a  = (f * 64'd1686629713) >> 30;
        t2 = (a * a) >> 30;
        r  = Q30U;
        r  = Q30U - (((t2 * r) >> 30) / 64'd110);
        r  = Q30U - (((t2 * r) >> 30) / 64'd72);
        r  = Q30U - (((t2 * r) >> 30) / 64'd42);
        r  = Q30U - (((t2 * r) >> 30) / 64'd20);
        r  = Q30U - (((t2 * r) >> 30) / 64'd6);
        r  = (a * r) >> 30;
        if (q >= 64'd2) begin
            return -$signed(r);
        end
        return $signed(r);
    endfunction

    // Windowed-sinc taps normalised to unity DC gain, scaled by gain, packed
    function automatic logic [NTAPS*KW-1:0] f_build_rom(input longint gain);
        longint raw [NTAPS];
        longint sum;
        longint d;
        longint ad;
        longint h;
        longint s;
        longint c;
        longint w;
        longint cv;
        longint unsigned u;
        longint unsigned mag;
        logic [NTAPS*KW-1:0] rom;
        int i;
        sum = 0;
        rom = '0;
        for (i = 0; i < NTAPS; i++) begin
            d  = 2 * longint'(i) - TAP_M;
            ad = (d < 0) ? -d : d;
            if (ad == 0) begin
                h = SINC_CENTRE;
            end else begin
                u   = (($unsigned(9 * ad) % SINC_DEN) << 32) / SINC_DEN;
                s   = f_sin_q30(u);
                // Truncate the quotient towards zero
                mag = (s < 0) ? $unsigned(-s) : $unsigned(s);
                mag = f_udiv(mag, $unsigned(ad));
                h   = (s < 0) ? -$signed(mag) : $signed(mag);
            end
            u = (($unsigned(4 * longint'(i) + TAP_M) % WIN_DEN) << 32) / WIN_DEN;
            c = f_sin_q30(u);
            w = 64'sd579820585 - (64'sd493921239 * c) / Q30;
            raw[i] = (h * w) / Q30;
            sum = sum + raw[i];
        end
        for (i = 0; i < NTAPS; i++) begin
            if (sum > 0) begin
                cv = raw[i] * 64'sd131072;
                if (cv >= 0) begin
                    cv = $signed(f_udiv($unsigned(cv + sum / 2), $unsigned(sum)));
                end else begin
                    cv = -$signed(f_udiv($unsigned(-cv + sum / 2), $unsigned(sum)));
                end
            end else begin
                cv = 0;
            end
            rom[i*KW +: KW] = KW'(cv * gain);
        end
        return rom;
    endfunction

    localparam logic [NTAPS*KW-1:0] ROM_DEC = f_build_rom(64'sd1);
    localparam logic [NTAPS*KW-1:0] ROM_INT = f_build_rom(longint'(RATIO));

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(fdi_pkg::SAT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(fdi_pkg::SAT_MIN);

    logic signed [KW-1:0]    w_coef;
    logic signed [PW-1:0]    n_prod;
    logic signed [PW-1:0]    r_prod;
    logic                    r_v1;
    logic                    r_f1;
    logic                    r_l1;
    logic signed [ACC_W-1:0] w_prod_x;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_v2;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [SW-1:0]    n_res;
    logic signed [SW-1:0]    r_res;
    logic                    r_done;

    // Look up the tap weight for this position; the interpolation table carries the gain
    always_comb begin
        if (i_mode == fdi_pkg::MODE_INTERP) begin
            w_coef = ROM_INT[i_tap_idx*KW +: KW];
        end else begin
            w_coef = ROM_DEC[i_tap_idx*KW +: KW];
        end
        n_prod = i_tap * w_coef;
    end

    // Restart the sum on the first tap, else add
    always_comb begin
        w_prod_x = ACC_W'(r_prod);
        n_acc    = r_f1 ? w_prod_x : (r_acc + w_prod_x);
    end

    // Round half up to Q1.15 and clamp
    always_comb begin
        w_rnd = (r_acc + ACC_W'(fdi_pkg::RND_HALF)) >>> fdi_pkg::FRAC_SHIFT;
        if (w_rnd > SAT_HI) begin
            n_res = SW'(fdi_pkg::SAT_MAX);
        end else if (w_rnd < SAT_LO) begin
            n_res = SW'(fdi_pkg::SAT_MIN);
        end else begin
            n_res = w_rnd[SW-1:0];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_ctrl.valid;
            r_v2   <= r_v1 & r_l1;
            r_done <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_f1   <= i_ctrl.first;
        r_l1   <= i_ctrl.last;
        r_prod <= n_prod;
        if (r_v1) begin
            r_acc <= n_acc;
        end
        if (r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== design/fir_decimate_interpolate.sv =====
// Top level of the integer-ratio FIR decimator/interpolator.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  input    | i_in_valid / o_in_ready     | i_sample_in, i_block_end
//  output   | o_out_valid / i_out_ready   | o_sample_out, o_last
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_mode
//
// Each filter output takes one full turn of the delay-line ring past the
// single multiplier, then the sum drains through the MAC pipeline and is
// handed off to the output register. Input is taken only while idle.
// Decimate: only the input that completes a group starts a sum. Interpolate:
// each input yields RATIO sums, on it and then on zero-stuffed samples. Reset
// is synchronous; it clears the delay line. A stalled output only holds the
// block when the next result is ready and the output register is still full.
module fir_decimate_interpolate #(
    parameter int RATIO      = 6,
    parameter int PHASE_TAPS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [fdi_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic                                  i_block_end,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [fdi_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                  o_last,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic                                  i_cfg_mode
);

    localparam int NTAPS = RATIO * PHASE_TAPS;
    localparam int TW    = $clog2(NTAPS);
    localparam int PHW   = $clog2(RATIO);
    localparam int SW    = fdi_pkg::SAMPLE_W;

    localparam logic [TW-1:0]  TAP_LAST = TW'(NTAPS - 1);
    localparam logic [PHW-1:0] PH_LAST  = PHW'(RATIO - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROT  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic                 r_mode;
    logic                 n_mode;
    logic [PHW-1:0]       r_phase;
    logic [PHW-1:0]       n_phase;
    logic [PHW-1:0]       r_sub;
    logic [PHW-1:0]       n_sub;
    logic [TW-1:0]        r_tap;
    logic [TW-1:0]        n_tap;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_last;
    logic                 n_out_last;

    logic                 w_in_xfer;
    logic                 w_out_free;
    logic                 w_load_out;
    logic                 w_shift;
    logic [SW-1:0]        w_head;
    logic [SW-1:0]        w_tap [NTAPS];
    logic [SW-1:0]        w_chain [NTAPS];
    fdi_pkg::t_mac_ctrl   w_ctrl;
    logic                 w_done;
    logic signed [SW-1:0] w_result;

    assign w_in_xfer  = i_in_valid & o_in_ready;
    assign w_out_free = ~r_out_valid | i_out_ready;

    // Sequencer: push, rotate the ring past the MAC, wait for the sum, hand off
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_sub      = r_sub;
        n_tap      = r_tap;
        w_shift    = 1'b0;
        w_head     = w_tap[NTAPS-1];
        w_ctrl     = '0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    w_shift = 1'b1;
                    w_head  = i_sample_in;
                    n_tap   = '0;
                    n_sub   = '0;
                    if (r_mode == fdi_pkg::MODE_DECIMATE) begin
                        if (r_phase >= PH_LAST) begin
                            n_phase = '0;
                            n_state = ST_ROT;
                        end else begin
                            n_phase = r_phase + 1'b1;
                        end
                    end else begin
                        n_state = ST_ROT;
                    end
                    if (i_block_end) begin
                        n_phase = '0;
                    end
                end
            end
            ST_ROT: begin
                w_shift      = 1'b1;
                w_ctrl.valid = 1'b1;
                w_ctrl.first = (r_tap == '0);
                w_ctrl.last  = (r_tap == TAP_LAST);
                n_tap        = r_tap + 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if ((r_mode == fdi_pkg::MODE_INTERP) && (r_sub != PH_LAST)) begin
                        // Push the zero-stuffed sample and run the next sum
                        w_shift = 1'b1;
                        w_head  = '0;
                        n_sub   = r_sub + 1'b1;
                        n_tap   = '0;
                        n_state = ST_ROT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once transferred
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out_last  = (r_mode == fdi_pkg::MODE_DECIMATE) || (r_sub == PH_LAST);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Mode register, written while idle
    always_comb begin
        n_mode = r_mode;
        if (i_cfg_valid && o_cfg_ready) begin
            n_mode = i_cfg_mode;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= fdi_pkg::MODE_DECIMATE;
            r_phase     <= '0;
            r_sub       <= '0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= w_result;
        end
        r_out_last <= n_out_last;
    end

    // Delay line: a ring of cells, new samples enter at the head
    for (genvar k = 0; k < NTAPS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_chain[k] = w_head;
        end else begin : g_link
            assign w_chain[k] = w_tap[k-1];
        end
        fdi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_chain[k]),
            .o_q     (w_tap[k])
        );
    end

    // Multiply-accumulate on the oldest cell as the ring turns
    fdi_mac #(
        .RATIO      (RATIO),
        .PHASE_TAPS (PHASE_TAPS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_tap_idx (r_tap),
        .i_tap     ($signed(w_tap[NTAPS-1])),
        .i_mode    (r_mode),
        .o_done    (w_done),
        .o_result  (w_result)
    );

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last       = r_out_last;
    assign o_cfg_ready  = (r_state == ST_IDLE);

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("sum finished outside the wait state");

    a_rot_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ROT) && (r_tap == TAP_LAST)) |=> (r_state == ST_WAIT))
        else $error("ring rotation did not end after a full turn");

    a_dec_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (r_mode == fdi_pkg::MODE_DECIMATE) && (r_phase < PH_LAST))
            |=> (r_state == ST_IDLE))
        else $error("decimator started a sum before the group was complete");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub <= PH_LAST) && (r_phase <= PH_LAST))
        else $error("phase counter out of range");
`endif

endmodule
